[rtl/core/tvs_pkg.sv]
package tvs_pkg;

   // Field and register widths
   localparam int EnergyW  = 48;
   localparam int CountW   = 21;
   localparam int StepW    = 32;
   localparam int TempW    = 32;
   localparam int PeriodW  = 16;
   localparam int DimW     = 2;
   localparam int FactorW  = 32;

   // Shared divider sizing
   localparam int DvdW     = 94;   // widest dividend: 34-bit radicand << 60
   localparam int DsrW     = 32;
   localparam int QuoW     = 64;
   localparam int NbitsW   = 7;

   localparam int DefMaxParticles = 1048576;

   localparam logic [FactorW-1:0] OneQ30  = 32'h4000_0000;
   localparam logic [FactorW-1:0] SatQ30  = 32'hFFFF_FFFF;

   // Register map (index = paddr[4:2])
   localparam logic [2:0] RegPeriod      = 3'd0;
   localparam logic [2:0] RegDimensions  = 3'd1;
   localparam logic [2:0] RegTargetTemp  = 3'd2;
   localparam logic [2:0] RegInitialTemp = 3'd3;
   localparam logic [2:0] RegMaxDelta    = 3'd4;
   localparam logic [2:0] RegCapEnable   = 3'd5;
   localparam logic [2:0] RegHoldMode    = 3'd6;
   localparam logic [2:0] RegTotalSteps  = 3'd7;

   // Divider start request
   typedef struct packed {
      logic              start;
      logic [NbitsW-1:0] nbits;
   } div_req_type;

endpackage

[rtl/core/tvs_div.sv]
module tvs_div (
   input  logic                          clock,
   input  logic                          reset,
   input  tvs_pkg::div_req_type          req,
   input  logic [tvs_pkg::DvdW-1:0]      dividend,
   input  logic [tvs_pkg::DsrW-1:0]      divisor,
   output logic                          done,
   output logic [tvs_pkg::QuoW-1:0]      quotient,
   output logic [tvs_pkg::DsrW-1:0]      remainder
);
   import tvs_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [NbitsW-1:0] cnt_ff, cnt_in;
   logic [DvdW-1:0]   dvd_ff, dvd_in;
   logic [DsrW-1:0]   rem_ff, rem_in;
   logic [QuoW-1:0]   quo_ff, quo_in;

   logic [DsrW:0]     trial;
   logic [DsrW:0]     diff;
   logic              fits;

   // One restoring step: bring down the next dividend bit
   assign trial = {rem_ff, dvd_ff[DvdW-1]};
   assign diff  = trial - {1'b0, divisor};
   assign fits  = trial >= {1'b0, divisor};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = req.nbits;
         dvd_in  = dividend;
         rem_in  = '0;
         quo_in  = '0;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[DvdW-2:0], 1'b0};
         rem_in = fits ? diff[DsrW-1:0] : trial[DsrW-1:0];
         quo_in = {quo_ff[QuoW-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == NbitsW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

[rtl/core/thermostat_velocity_scale_top.sv]
// Velocity-rescaling thermostat: scale factor for one simulation step.
// Request channel (req_*): mode, kinetic_energy (Q32.16), particle_count and
// elapsed_steps, valid/ready. Response channel (rsp_*): apply_scale,
// scale_factor (Q2.30), temperature (Q16.16) and invalid, valid/ready.
// Registers sit on the csr_* APB port at byte address 4*index.
// One request is in flight at a time; req_ready is high only when idle.
// Work runs on one shared bit-serial divider and a two-bit-per-cycle
// square root, in order: temperature division, period check, ramp
// division, radicand division, square root. A hold-mode or few-steps-left
// request skips the ramp division; a step that does not apply skips it and
// also the radicand division and the square root; an initial-scaling
// request skips the period check and the ramp division. Zero temperature or a
// saturated factor skips the radicand division and the square root.
// The response is held in output registers until rsp_ready takes it; the
// next request is accepted after that.
// Reset (synchronous, active high) loads the register defaults and clears
// the step counter; no clearing pass is needed.
module thermostat_velocity_scale_top #(
   parameter int MAX_PARTICLES = tvs_pkg::DefMaxParticles
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_mode,
   input  logic [tvs_pkg::EnergyW-1:0]    req_kinetic_energy,
   input  logic [tvs_pkg::CountW-1:0]     req_particle_count,
   input  logic [tvs_pkg::StepW-1:0]      req_elapsed_steps,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_apply_scale,
   output logic [tvs_pkg::FactorW-1:0]    rsp_scale_factor,
   output logic [tvs_pkg::TempW-1:0]      rsp_temperature,
   output logic                           rsp_invalid,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [4:0]                     csr_paddr,
   input  logic [31:0]                    csr_pwdata,
   output logic [31:0]                    csr_prdata,
   output logic                           csr_pready
);
   import tvs_pkg::*;

   localparam logic [24:0] MaxCnt = 25'(MAX_PARTICLES);

   typedef enum logic [3:0] {
      ST_IDLE, ST_TEMP, ST_TDIV, ST_MODE, ST_MOD, ST_MUL, ST_RDIV,
      ST_CHECK, ST_FDIV, ST_SQRT, ST_OUT
   } state_type;

   // Configuration registers
   logic [PeriodW-1:0] period_ff;
   logic [DimW-1:0]    dim_ff;
   logic [TempW-1:0]   target_ff, initial_ff, max_delta_ff;
   logic               cap_ff, hold_ff;
   logic [StepW-1:0]   total_ff;
   logic [2:0]         reg_idx;
   logic               csr_wr;

   assign reg_idx    = csr_paddr[4:2];
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff    <= 16'd1;
         dim_ff       <= 2'd3;
         target_ff    <= 32'd65536;
         initial_ff   <= 32'd65536;
         max_delta_ff <= '0;
         cap_ff       <= 1'b0;
         hold_ff      <= 1'b0;
         total_ff     <= 32'd1000;
      end else if (csr_wr) begin
         unique case (reg_idx)
            RegPeriod:      period_ff    <= csr_pwdata[PeriodW-1:0];
            RegDimensions:  dim_ff       <= csr_pwdata[DimW-1:0];
            RegTargetTemp:  target_ff    <= csr_pwdata;
            RegInitialTemp: initial_ff   <= csr_pwdata;
            RegMaxDelta:    max_delta_ff <= csr_pwdata;
            RegCapEnable:   cap_ff       <= csr_pwdata[0];
            RegHoldMode:    hold_ff      <= csr_pwdata[0];
            RegTotalSteps:  total_ff     <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         RegPeriod:      csr_prdata = {16'd0, period_ff};
         RegDimensions:  csr_prdata = {30'd0, dim_ff};
         RegTargetTemp:  csr_prdata = target_ff;
         RegInitialTemp: csr_prdata = initial_ff;
         RegMaxDelta:    csr_prdata = max_delta_ff;
         RegCapEnable:   csr_prdata = {31'd0, cap_ff};
         RegHoldMode:    csr_prdata = {31'd0, hold_ff};
         RegTotalSteps:  csr_prdata = total_ff;
         default:        csr_prdata = '0;
      endcase
   end

   // Sequencer registers
   state_type          state_ff, state_in;
   logic               mode_ff, mode_in;
   logic [EnergyW-1:0] energy_ff, energy_in;
   logic [CountW-1:0]  count_ff, count_in;
   logic [StepW-1:0]   elapsed_ff, elapsed_in;
   logic [StepW-1:0]   step_ff, step_in;
   logic [TempW-1:0]   temp_ff, temp_in;
   logic               apply_ff, apply_in;
   logic               invalid_ff, invalid_in;
   logic [FactorW-1:0] factor_ff, factor_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [34:0] num_ff, num_in;
   logic [32:0]        magc_ff, magc_in;
   logic               neg_ff, neg_in;
   logic [63:0]        sq_ff, sq_in;
   logic [31:0]        root_ff, root_in;
   logic [33:0]        srem_ff, srem_in;
   logic [4:0]         scnt_ff, scnt_in;
   div_req_type        div_req_ff, div_req_in;
   logic [DvdW-1:0]    div_dvd_ff, div_dvd_in;
   logic [DsrW-1:0]    div_dsr_ff, div_dsr_in;

   logic               div_done;
   logic [QuoW-1:0]    div_quo;
   logic [DsrW-1:0]    div_rem;

   tvs_div u_div (
      .clock     (clock),
      .reset     (reset),
      .req       (div_req_ff),
      .dividend  (div_dvd_ff),
      .divisor   (div_dsr_ff),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // Denominator N*dim with particle clamp
   logic [CountW-1:0]  cnt_clamp;
   logic [22:0]        den;
   assign cnt_clamp = ({4'd0, count_ff} > MaxCnt) ? MaxCnt[CountW-1:0] : count_ff;
   assign den       = 23'(cnt_clamp) * 23'(dim_ff);

   // Effective period
   logic [PeriodW-1:0] per;
   assign per = (period_ff == '0) ? PeriodW'(1) : period_ff;

   // Difference to target, optionally capped
   logic signed [33:0] diff;
   logic [32:0]        mag, magc;
   logic signed [34:0] capped;
   logic signed [33:0] left;
   logic               few_left;
   assign diff     = $signed({2'b00, target_ff}) - $signed({2'b00, temp_ff});
   assign mag      = diff[33] ? 33'(-diff) : diff[32:0];
   assign magc     = (cap_ff && mag > {1'b0, max_delta_ff}) ? {1'b0, max_delta_ff} : mag;
   assign capped   = diff[33] ? -$signed({2'b00, magc}) : $signed({2'b00, magc});
   assign left     = $signed({2'b00, total_ff}) - $signed({2'b00, elapsed_ff});
   assign few_left = $signed({18'd0, per}) > left;

   // Ramp increment: capped directly, or from the ramp division
   logic signed [34:0] inc_raw, inc_cap, num_ramp;
   always_comb begin
      if (state_ff == ST_RDIV) begin
         inc_raw = neg_ff ? -$signed({1'b0, div_quo[33:0]}) : $signed({1'b0, div_quo[33:0]});
      end else begin
         inc_raw = capped;
      end
      inc_cap  = (cap_ff && inc_raw > $signed({3'b000, max_delta_ff}))
                 ? $signed({3'b000, max_delta_ff}) : inc_raw;
      num_ramp = $signed({3'b000, temp_ff}) + inc_cap;
   end

   // Radicand clamp and saturation check
   logic [33:0] num_pos;
   logic        ratio_sat;
   assign num_pos   = num_ff[34] ? '0 : num_ff[33:0];
   assign ratio_sat = {2'b00, num_pos} >= {temp_ff, 4'b0000};

   // Square root step, two radicand bits per cycle
   logic [33:0] srem_try, sqrt_trial;
   logic        sqrt_fits;
   logic [31:0] root_next;
   assign srem_try   = {srem_ff[31:0], sq_ff[63:62]};
   assign sqrt_trial = {root_ff, 2'b01};
   assign sqrt_fits  = srem_try >= sqrt_trial;
   assign root_next  = {root_ff[30:0], sqrt_fits};

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      energy_in    = energy_ff;
      count_in     = count_ff;
      elapsed_in   = elapsed_ff;
      step_in      = step_ff;
      temp_in      = temp_ff;
      apply_in     = apply_ff;
      invalid_in   = invalid_ff;
      factor_in    = factor_ff;
      rsp_valid_in = rsp_valid_ff;
      num_in       = num_ff;
      magc_in      = magc_ff;
      neg_in       = neg_ff;
      sq_in        = sq_ff;
      root_in      = root_ff;
      srem_in      = srem_ff;
      scnt_in      = scnt_ff;
      div_req_in   = '0;
      div_dvd_in   = div_dvd_ff;
      div_dsr_in   = div_dsr_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               mode_in    = req_mode;
               energy_in  = req_kinetic_energy;
               count_in   = req_particle_count;
               elapsed_in = req_elapsed_steps;
               state_in   = ST_TEMP;
            end
         end
         // T = 2E / (N*dim)
         ST_TEMP: begin
            if (den == '0) begin
               temp_in  = '0;
               state_in = ST_MODE;
            end else begin
               div_req_in = '{start: 1'b1, nbits: NbitsW'(49)};
               div_dvd_in = {energy_ff, 1'b0, 45'd0};
               div_dsr_in = 32'(den);
               state_in   = ST_TDIV;
            end
         end
         ST_TDIV: begin
            if (div_done) begin
               temp_in  = (div_quo[63:32] != '0) ? SatQ30 : div_quo[31:0];
               state_in = ST_MODE;
            end
         end
         ST_MODE: begin
            if (mode_ff) begin
               apply_in = 1'b1;
               num_in   = $signed({3'b000, initial_ff});
               state_in = ST_CHECK;
            end else begin
               div_req_in = '{start: 1'b1, nbits: NbitsW'(32)};
               div_dvd_in = {step_ff, 62'd0};
               div_dsr_in = {16'd0, per};
               state_in   = ST_MOD;
            end
         end
         // step_counter mod period decides whether to apply
         ST_MOD: begin
            if (div_done) begin
               step_in  = step_ff + 1'b1;
               apply_in = (div_rem == '0);
               magc_in  = magc;
               neg_in   = diff[33];
               if (div_rem != '0) begin
                  factor_in    = OneQ30;
                  invalid_in   = 1'b0;
                  rsp_valid_in = 1'b1;
                  state_in     = ST_OUT;
               end else if (hold_ff) begin
                  num_in   = cap_ff ? ($signed({3'b000, temp_ff}) + capped)
                                    : $signed({3'b000, target_ff});
                  state_in = ST_CHECK;
               end else if (few_left) begin
                  num_in   = num_ramp;
                  state_in = ST_CHECK;
               end else begin
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            state_in = ST_RDIV;
            div_req_in = '{start: 1'b1, nbits: NbitsW'(49)};
            div_dvd_in = {49'(per) * 49'(magc_ff), 45'd0};
            div_dsr_in = left[31:0];
         end
         ST_RDIV: begin
            if (div_done) begin
               num_in   = num_ramp;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (temp_ff == '0) begin
               factor_in    = OneQ30;
               invalid_in   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_OUT;
            end else if (ratio_sat) begin
               factor_in    = SatQ30;
               invalid_in   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_OUT;
            end else begin
               div_req_in = '{start: 1'b1, nbits: NbitsW'(DvdW)};
               div_dvd_in = {num_pos, 60'd0};
               div_dsr_in = temp_ff;
               state_in   = ST_FDIV;
            end
         end
         // floor(num * 2^60 / T), then its square root
         ST_FDIV: begin
            if (div_done) begin
               sq_in    = div_quo;
               root_in  = '0;
               srem_in  = '0;
               scnt_in  = '0;
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            sq_in   = {sq_ff[61:0], 2'b00};
            srem_in = sqrt_fits ? (srem_try - sqrt_trial) : srem_try;
            root_in = root_next;
            scnt_in = scnt_ff + 1'b1;
            if (scnt_ff == 5'd31) begin
               factor_in    = root_next;
               invalid_in   = 1'b0;
               rsp_valid_in = 1'b1;
               state_in     = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         div_req_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         div_req_ff   <= div_req_in;
      end
      mode_ff    <= mode_in;
      energy_ff  <= energy_in;
      count_ff   <= count_in;
      elapsed_ff <= elapsed_in;
      temp_ff    <= temp_in;
      apply_ff   <= apply_in;
      invalid_ff <= invalid_in;
      factor_ff  <= factor_in;
      num_ff     <= num_in;
      magc_ff    <= magc_in;
      neg_ff     <= neg_in;
      sq_ff      <= sq_in;
      root_ff    <= root_in;
      srem_ff    <= srem_in;
      scnt_ff    <= scnt_in;
      div_dvd_ff <= div_dvd_in;
      div_dsr_ff <= div_dsr_in;
   end

   assign req_ready        = (state_ff == ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_apply_scale  = apply_ff;
   assign rsp_scale_factor = factor_ff;
   assign rsp_temperature  = temp_ff;
   assign rsp_invalid      = invalid_ff;

endmodule

[test/tb.sv]
module tb;
   import tvs_pkg::*;

   typedef struct {
      logic              apply;
      logic [FactorW-1:0] factor;
      logic [TempW-1:0]  temp;
      logic              inv;
   } scale_result_type;

   typedef struct {
      logic               mode;
      logic [EnergyW-1:0] energy;
      logic [CountW-1:0]  count;
      logic [StepW-1:0]   elapsed;
      logic               pinned;
      scale_result_type   res;
   } step_row_type;

   localparam int WatchLimit = 3000;
   localparam int LongHold   = 400;
   localparam int MAX_PART   = DefMaxParticles;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0, req_ready, req_mode = 1'b0;
   logic [EnergyW-1:0] req_kinetic_energy = '0;
   logic [CountW-1:0]  req_particle_count = '0;
   logic [StepW-1:0]   req_elapsed_steps = '0;
   logic rsp_valid, rsp_ready = 1'b0, rsp_apply_scale, rsp_invalid;
   logic [FactorW-1:0] rsp_scale_factor;
   logic [TempW-1:0]   rsp_temperature;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0, csr_pready;
   logic [4:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0, csr_prdata;

   // typed-in expectation travels with the request payload
   logic             row_pinned = 1'b0;
   scale_result_type row_res = '{1'b0, '0, '0, 1'b0};

   // predictor copy of the registers and step count
   logic [15:0] cfg_period = 16'd1;
   logic [1:0]  cfg_dims = 2'd3;
   logic [31:0] cfg_target = 32'd65536, cfg_initial = 32'd65536, cfg_max_delta = '0;
   logic        cfg_cap = 1'b0, cfg_hold = 1'b0;
   logic [31:0] cfg_total = 32'd1000;
   logic [31:0] step_count = '0;

   scale_result_type expected_q[$];
   int  errors = 0;
   int  stall_cnt = 0;
   bit  hold_off_req = 0;
   bit  no_idle = 0;

   always #5 clock = ~clock;

   thermostat_velocity_scale_top u_top (.*);

   // floor(2^30 * sqrt(num / t)), t nonzero
   function automatic logic [31:0] root_of_ratio(logic [63:0] num, logic [31:0] t,
                                                 output logic sat);
      logic [63:0] q, r, v, res, bitv;
      q = num / t;
      r = num % t;
      sat = 1'b0;
      if (q >= 16) begin
         sat = 1'b1;
         return SatQ30;
      end
      for (int i = 0; i < 60; i++) begin
         r = r << 1;
         q = q << 1;
         if (r >= t) begin
            r = r - t;
            q[0] = 1'b1;
         end
      end
      v = q;
      res = '0;
      bitv = 64'h1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res[31:0];
   endfunction

   function automatic scale_result_type predict_scale(logic mode, logic [47:0] energy,
                                                      logic [20:0] count, logic [31:0] elapsed);
      scale_result_type o;
      logic [63:0] n, den, q;
      logic [31:0] per;
      longint diff, mag, capped, left, inc, num;
      logic sat;
      n = (count > MAX_PART) ? 64'(MAX_PART) : 64'(count);
      den = n * cfg_dims;
      per = (cfg_period == 0) ? 32'd1 : 32'(cfg_period);
      o.factor = OneQ30;
      o.inv = 1'b0;
      num = 0;
      if (den == 0) o.temp = '0;
      else begin
         q = {15'd0, energy, 1'b0} / den;
         o.temp = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
      end
      if (mode) begin
         o.apply = 1'b1;
         num = longint'({32'd0, cfg_initial});
      end else begin
         o.apply = (step_count % per) == 0;
         if (o.apply) begin
            diff = longint'({32'd0, cfg_target}) - longint'({32'd0, o.temp});
            mag = diff < 0 ? -diff : diff;
            capped = diff;
            if (cfg_cap) begin
               if (mag > longint'({32'd0, cfg_max_delta})) mag = longint'({32'd0, cfg_max_delta});
               capped = diff < 0 ? -mag : mag;
            end
            if (cfg_hold) begin
               num = cfg_cap ? longint'({32'd0, o.temp}) + capped : longint'({32'd0, cfg_target});
            end else begin
               left = longint'({32'd0, cfg_total}) - longint'({32'd0, elapsed});
               if (longint'({32'd0, per}) > left) inc = capped;
               else inc = (longint'({32'd0, per}) * capped) / left;
               if (cfg_cap && inc > longint'({32'd0, cfg_max_delta}))
                  inc = longint'({32'd0, cfg_max_delta});
               num = longint'({32'd0, o.temp}) + inc;
            end
         end
      end
      if (o.apply) begin
         if (o.temp == 0) begin
            o.factor = OneQ30;
            o.inv = 1'b1;
         end else begin
            if (num < 0) num = 0;
            o.factor = root_of_ratio(64'(num), o.temp, sat);
            o.inv = sat;
         end
      end
      return o;
   endfunction

   // request side: record the expectation of each accepted request
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         if (row_pinned) expected_q.push_back(row_res);
         else expected_q.push_back(predict_scale(req_mode, req_kinetic_energy,
                                                 req_particle_count, req_elapsed_steps));
         if (!req_mode) step_count <= step_count + 1;
      end
   end

   // response side: compare against the oldest expectation
   always @(posedge clock) begin
      scale_result_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_q.size() == 0) begin
            $display("%0t: response with nothing expected", $time);
            errors++;
         end else begin
            e = expected_q.pop_front();
            if (rsp_apply_scale !== e.apply) begin
               $display("%0t: apply_scale exp %0d got %0d", $time, e.apply, rsp_apply_scale);
               errors++;
            end
            if (rsp_scale_factor !== e.factor) begin
               $display("%0t: scale_factor exp %h got %h", $time, e.factor, rsp_scale_factor);
               errors++;
            end
            if (rsp_temperature !== e.temp) begin
               $display("%0t: temperature exp %h got %h", $time, e.temp, rsp_temperature);
               errors++;
            end
            if (rsp_invalid !== e.inv) begin
               $display("%0t: invalid exp %0d got %0d", $time, e.inv, rsp_invalid);
               errors++;
            end
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) stall_cnt <= 0;
      else stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= WatchLimit) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // receiver with random stalls and one long hold-off
   initial begin
      int gap;
      @(negedge reset);
      @(posedge clock);
      forever begin
         if (hold_off_req) gap = LongHold;
         else gap = no_idle ? 0 : $urandom_range(0, 10);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
            hold_off_req = 0;
         end
         rsp_ready <= 1'b1;
         do @(negedge clock); while (!rsp_valid);
         @(posedge clock);
      end
   end

   task automatic csr_write(logic [2:0] idx, logic [31:0] val);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         RegPeriod:      cfg_period = val[15:0];
         RegDimensions:  cfg_dims = val[1:0];
         RegTargetTemp:  cfg_target = val;
         RegInitialTemp: cfg_initial = val;
         RegMaxDelta:    cfg_max_delta = val;
         RegCapEnable:   cfg_cap = val[0];
         RegHoldMode:    cfg_hold = val[0];
         RegTotalSteps:  cfg_total = val;
         default: ;
      endcase
   endtask

   task automatic send_request(step_row_type row);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= row.mode;
      req_kinetic_energy <= row.energy;
      req_particle_count <= row.count;
      req_elapsed_steps <= row.elapsed;
      row_pinned <= row.pinned;
      row_res <= row.res;
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
   endtask

   // wait for the falling edge so the last accepted request is already queued
   task automatic drain_responses();
      req_valid <= 1'b0;
      @(negedge clock);
      while (expected_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_word();
      return $urandom >> $urandom_range(0, 31);
   endfunction

   // random step: content near the target in about half the steps so the ramp math matters
   function automatic step_row_type rand_step();
      step_row_type r;
      logic [63:0] goal, e;
      r.pinned = 1'b0;
      r.res = '{1'b0, '0, '0, 1'b0};
      r.mode = ($urandom_range(0, 9) == 0);
      r.count = ($urandom_range(0, 7) == 0) ? 21'($urandom) : 21'($urandom >> $urandom_range(11, 31));
      if ($urandom_range(0, 2) == 0) begin
         r.energy = {16'($urandom), 32'($urandom)} >> $urandom_range(0, 47);
      end else begin
         goal = 64'(cfg_target) + $urandom_range(0, 4000) - 2000;
         if ($urandom_range(0, 3) == 0) goal = 64'(rand_word());
         e = goal * r.count * (cfg_dims == 0 ? 2'd3 : cfg_dims) / 2;
         r.energy = e[47:0];
      end
      case ($urandom_range(0, 3))
         0: r.elapsed = $urandom;
         1: r.elapsed = cfg_total + $urandom_range(0, 3);
         default: r.elapsed = cfg_total - $urandom_range(0, 300);
      endcase
      return r;
   endfunction

   step_row_type dir_rows[12] = '{
      '{1'b0, 48'd0, 21'd1, 32'd0, 1'b1, '{1'b1, OneQ30, 32'd0, 1'b1}},
      '{1'b0, 48'd5, 21'd0, 32'd1, 1'b1, '{1'b1, OneQ30, 32'd0, 1'b1}},
      '{1'b0, 48'd98304, 21'd1, 32'd2, 1'b1, '{1'b1, OneQ30, 32'h1_0000, 1'b0}},
      '{1'b1, 48'd3, 21'd1, 32'd0, 1'b1, '{1'b1, SatQ30, 32'd2, 1'b1}},
      '{1'b1, 48'd0, 21'd1, 32'd0, 1'b1, '{1'b1, OneQ30, 32'd0, 1'b1}},
      '{1'b0, 48'hFFFF_FFFF_FFFF, 21'd1, 32'd3, 1'b0, '{1'b0, '0, '0, 1'b0}},
      '{1'b0, 48'hFFFF_FFFF_FFFF, 21'h1F_FFFF, 32'd4, 1'b0, '{1'b0, '0, '0, 1'b0}},
      '{1'b0, 48'h8000, 21'h10_0000, 32'd999, 1'b0, '{1'b0, '0, '0, 1'b0}},
      '{1'b0, 48'd1234567, 21'd3, 32'd1000, 1'b0, '{1'b0, '0, '0, 1'b0}},
      '{1'b0, 48'd1234567, 21'd3, 32'hFFFF_FFFF, 1'b0, '{1'b0, '0, '0, 1'b0}},
      '{1'b1, 48'h3_0000, 21'd1, 32'd0, 1'b0, '{1'b0, '0, '0, 1'b0}},
      '{1'b0, 48'h5555_0000, 21'd7, 32'd500, 1'b0, '{1'b0, '0, '0, 1'b0}}
   };

   // main sequence: directed table, then register phases with random steps
   initial begin
      logic [15:0] per;
      logic [1:0]  dims;
      logic [31:0] tgt, init, md, tot;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (dir_rows[i]) send_request(dir_rows[i]);
      drain_responses();

      for (int p = 0; p < 10; p++) begin
         per  = (p == 1) ? 16'd0 : (p == 9) ? 16'hFFFF : 16'($urandom_range(1, 4));
         dims = (p == 1) ? 2'd0 : (p == 2) ? 2'd1 : 2'($urandom_range(1, 3));
         tgt  = (p == 3) ? 32'd0 : (p == 9) ? 32'hFFFF_FFFF : rand_word();
         init = (p == 3) ? 32'd0 : (p == 9) ? 32'hFFFF_FFFF : rand_word();
         md   = (p == 3) ? 32'd0 : (p == 9) ? 32'hFFFF_FFFF : rand_word() >> 4;
         tot  = (p == 9) ? 32'hFFFF_FFFF : (p == 5) ? 32'd1 : $urandom_range(1, 5000);
         csr_write(RegPeriod, {16'd0, per});
         csr_write(RegDimensions, {30'd0, dims});
         csr_write(RegTargetTemp, tgt);
         csr_write(RegInitialTemp, init);
         csr_write(RegMaxDelta, md);
         csr_write(RegCapEnable, {31'd0, p[0]});
         csr_write(RegHoldMode, {31'd0, p[1]});
         csr_write(RegTotalSteps, tot);
         no_idle = (p == 5);
         if (p == 4) hold_off_req = 1;
         for (int k = 0; k < 155; k++) begin
            if (p == 6 && k == 70) drain_responses();
            send_request(rand_step());
         end
         drain_responses();
      end
      no_idle = 0;

      if (errors == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
